// File: design/idwl_pkg.sv
// ----------------------------------------------------------------------------
// idwl_pkg
// Types and constants shared by the ID whitelist with usage quota block.
// ----------------------------------------------------------------------------
package idwl_pkg;

  localparam int ID_W    = 32;
  localparam int AMT_W   = 32;
  localparam int CNT_W   = 34;
  localparam int IDX_W   = 4;

  localparam logic [CNT_W-1:0] QUOTA_RESET = 34'd10000000000;
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SUM,
    S_WB,
    S_PUSH
  } state_t;

  // one result item
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] entry_index;
    logic [CNT_W-1:0] new_count;
    logic             revoked;
    logic             table_full;
  } rsp_t;

  // controls and data broadcast to every cell of the chain
  typedef struct packed {
    logic             cmp_en;
    logic             load_en;
    logic             upd_en;
    logic             shift_en;
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amt;
    logic [CNT_W-1:0] sum;
  } cell_bc_t;

endpackage

// File: design/idwl_if.sv
// ----------------------------------------------------------------------------
// idwl_if
// Valid/ready channels of the whitelist block: request, result, quota write.
// ----------------------------------------------------------------------------
interface idwl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] user_id;
  logic [31:0] amount;

  modport source (output valid, command, user_id, amount, input ready);
  modport sink   (input valid, command, user_id, amount, output ready);
endinterface

interface idwl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [3:0]  entry_index;
  logic [33:0] new_count;
  logic        revoked;
  logic        table_full;

  modport source (output valid, found, entry_index, new_count, revoked, table_full,
                  input ready);
  modport sink   (input valid, found, entry_index, new_count, revoked, table_full,
                  output ready);
endinterface

interface idwl_cfg_if;
  logic        valid;
  logic        ready;
  logic [33:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/idwl_cell.sv
// ----------------------------------------------------------------------------
// idwl_cell
// One table slot: holds an ID and its count, compares against the broadcast
// ID and shifts its contents down from the neighbour above on a revoke.
// ----------------------------------------------------------------------------
module idwl_cell
  import idwl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_bc_t         bc,
  input  logic             valid,    // slot lies below the fill level
  input  logic             tail,     // slot is the next free one
  input  logic             any_in,   // a lower slot matched
  input  logic [ID_W-1:0]  nb_id,    // contents of the slot above
  input  logic [CNT_W-1:0] nb_cnt,
  output logic [ID_W-1:0]  id_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             any_out,
  output logic             first,
  output logic [CNT_W-1:0] sel_cnt
);

  logic [ID_W-1:0]  id_r;
  logic [CNT_W-1:0] cnt_r;
  logic             match_r;

  // match flag, latched once per access request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (bc.cmp_en) begin
      match_r <= valid && (id_r == bc.id);
    end
  end

  assign any_out = any_in | match_r;
  assign first   = match_r & ~any_in;
  assign sel_cnt = first ? cnt_r : '0;

  // slot contents: append, count update or shift down
  always_ff @(posedge clk) begin
    if (bc.load_en && tail) begin
      id_r  <= bc.id;
      cnt_r <= CNT_W'(bc.amt);
    end else if (bc.upd_en && first) begin
      cnt_r <= bc.sum;
    end else if (bc.shift_en && any_out) begin
      id_r  <= nb_id;
      cnt_r <= nb_cnt;
    end
  end

  assign id_o  = id_r;
  assign cnt_o = cnt_r;

endmodule

// File: design/id_whitelist_with_usage_quota.sv
// ----------------------------------------------------------------------------
// id_whitelist_with_usage_quota
// Whitelist of user IDs with per-entry usage counts and a revoke quota.
// ----------------------------------------------------------------------------
// The request is registered at acceptance. A load then writes its slot. In an
// access every cell of the chain compares its ID, then the lowest match is
// picked and the saturated sum formed, and, on a hit, the cells are written
// back or shifted down. The result then moves into the output register once
// the output slot is free. One request is in the chain at a time. The next is
// accepted in the cycle after the result is registered. It is accepted even
// while the previous result waits to be taken. A result that still waits when
// the next one is ready holds the chain until it is taken.
// The table comes up empty after reset with no clearing pass; usage_quota
// resets to 10000000000 and may be rewritten while the block is idle.
module id_whitelist_with_usage_quota
  import idwl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  idwl_in_if.sink    in_req,
  idwl_out_if.source out_rsp,
  idwl_cfg_if.sink   cfg_wr
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t           state_r, state_nxt;
  logic             cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [AMT_W-1:0] amt_r;
  logic [CNT_W-1:0] quota_r;
  logic [LW-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [IW-1:0]    hit_r, hit_nxt;
  rsp_t             res_r, res_nxt;
  rsp_t             out_r;
  logic             out_valid_r, out_valid_nxt;
  cell_bc_t         bc;

  logic [ID_W-1:0]  c_id   [CAPACITY];
  logic [CNT_W-1:0] c_cnt  [CAPACITY];
  logic [CNT_W-1:0] c_sel  [CAPACITY];
  logic             c_any  [CAPACITY];
  logic             c_first[CAPACITY];

  logic             hit;
  logic [CNT_W-1:0] hit_cnt;
  logic [IW-1:0]    hit_idx;
  logic [CNT_W:0]   raw_sum;
  logic             full;
  logic             slot_free;

  // quota register
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r <= QUOTA_RESET;
    end else if (cfg_wr.valid) begin
      quota_r <= cfg_wr.data;
    end
  end

  // request capture
  assign in_req.ready = (state_r == S_IDLE);
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      cmd_r <= in_req.command;
      id_r  <= in_req.user_id;
      amt_r <= in_req.amount;
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             any_in;
    logic [ID_W-1:0]  nb_id;
    logic [CNT_W-1:0] nb_cnt;

    if (i == 0) begin : g_bot
      assign any_in = 1'b0;
    end else begin : g_mid
      assign any_in = c_any[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign nb_id  = '0;
      assign nb_cnt = '0;
    end else begin : g_low
      assign nb_id  = c_id[i+1];
      assign nb_cnt = c_cnt[i+1];
    end

    idwl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bc      (bc),
      .valid   (LW'(i) < live_r),
      .tail    (LW'(i) == live_r),
      .any_in  (any_in),
      .nb_id   (nb_id),
      .nb_cnt  (nb_cnt),
      .id_o    (c_id[i]),
      .cnt_o   (c_cnt[i]),
      .any_out (c_any[i]),
      .first   (c_first[i]),
      .sel_cnt (c_sel[i])
    );
  end

  // lowest match: count and position (one-hot, so OR-combine)
  always_comb begin
    hit_cnt = '0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_cnt = hit_cnt | c_sel[i];
      hit_idx = hit_idx | (c_first[i] ? IW'(i) : IW'(0));
    end
  end
  assign hit     = c_any[CAPACITY-1];
  assign raw_sum = {1'b0, hit_cnt} + (CNT_W+1)'(amt_r);
  assign full    = (live_r == LW'(CAPACITY));
  assign slot_free = !out_valid_r || out_rsp.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    sum_nxt       = sum_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    bc            = '0;
    bc.id         = id_r;
    bc.amt        = amt_r;
    bc.sum        = sum_r;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        res_nxt = '0;
        if (cmd_r == CMD_LOAD) begin
          if (full) begin
            res_nxt.table_full = 1'b1;
          end else begin
            bc.load_en          = 1'b1;
            res_nxt.found       = 1'b1;
            res_nxt.entry_index = IDX_W'(live_r);
            res_nxt.new_count   = CNT_W'(amt_r);
            live_nxt            = live_r + LW'(1);
          end
          state_nxt = S_PUSH;
        end else begin
          bc.cmp_en = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = raw_sum[CNT_W] ? CNT_MAX : raw_sum[CNT_W-1:0];
        hit_nxt   = hit_idx;
        state_nxt = hit ? S_WB : S_PUSH;
      end
      S_WB: begin
        res_nxt.found       = 1'b1;
        res_nxt.entry_index = IDX_W'(hit_r);
        res_nxt.new_count   = sum_r;
        if (sum_r > quota_r) begin
          bc.shift_en     = 1'b1;
          res_nxt.revoked = 1'b1;
          live_nxt        = live_r - LW'(1);
        end else begin
          bc.upd_en = 1'b1;
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    if (state_r == S_PUSH && slot_free) begin
      out_r <= res_r;
    end
  end

  // result channel
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = out_r.found;
  assign out_rsp.entry_index = out_r.entry_index;
  assign out_rsp.new_count   = out_r.new_count;
  assign out_rsp.revoked     = out_r.revoked;
  assign out_rsp.table_full  = out_r.table_full;

endmodule

// File: design/idwl_checker.sv
// ----------------------------------------------------------------------------
// idwl_checker
// Port-level checks on the whitelist block, bound to the top level.
// ----------------------------------------------------------------------------
module idwl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [3:0]  entry_index,
  input logic [33:0] new_count,
  input logic        revoked,
  input logic        table_full
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // the block comes out of reset with no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // only a matched entry can be revoked
  a_rev_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && revoked |-> found && !table_full)
    else $error("revoke without a match");

  // a refused or missed request reports no entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> entry_index == 4'd0 && new_count == 34'd0 && !revoked)
    else $error("miss or full result carries entry data");

endmodule

bind id_whitelist_with_usage_quota idwl_checker u_idwl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .found       (out_rsp.found),
  .entry_index (out_rsp.entry_index),
  .new_count   (out_rsp.new_count),
  .revoked     (out_rsp.revoked),
  .table_full  (out_rsp.table_full)
);
